[hdl/lpg_pkg.sv]
// ----------------------------------------------------------------------------
// Line pixel generator package
// Shared widths, types and helper functions for the line pixel generator.
// ----------------------------------------------------------------------------
package lpg_pkg;

    // Coordinate and colour widths.
    localparam int COORD_BITS = 12;
    localparam int COLOR_BITS = 32;

    // The doubled minor delta and the biased error term need extra headroom.
    localparam int STEP_BITS = COORD_BITS + 1;
    localparam int ERR_BITS  = COORD_BITS + 2;

    // Command queue between the front and the back.
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 2 ** QUEUE_AW;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [COLOR_BITS-1:0] t_color;

    // Item kinds on the input channel.
    typedef enum logic {
        KIND_START = 1'b0,
        KIND_STEP  = 1'b1
    } t_kind;

    // A classified item as held in the queue. For a start item the endpoints
    // are already swapped into major/minor form and ordered by the major axis.
    typedef struct packed {
        t_kind  kind;
        logic   steep;
        t_coord major_lo;
        t_coord minor_lo;
        t_coord major_hi;
        t_coord minor_hi;
        t_color color;
    } t_cmd;

    // Status of the back part, seen by the top level.
    typedef struct packed {
        logic active;
        logic emit;
        logic emit_last;
    } t_back_status;

    // Absolute difference of two coordinates.
    function automatic t_coord abs_diff(input t_coord a, input t_coord b);
        t_coord d;
        d = (a > b) ? (a - b) : (b - a);
        return d;
    endfunction

endpackage

[hdl/lpg_if.sv]
// ----------------------------------------------------------------------------
// Line pixel generator channels
// Valid/ready interfaces for line items in and pixels out.
// ----------------------------------------------------------------------------

// Input channel: start items and step requests.
interface lpg_line_if;
    logic                 valid;
    logic                 ready;
    logic                 kind;
    lpg_pkg::t_coord      start_x;
    lpg_pkg::t_coord      start_y;
    lpg_pkg::t_coord      end_x;
    lpg_pkg::t_coord      end_y;
    lpg_pkg::t_color      line_color;

    modport source (
        output valid, kind, start_x, start_y, end_x, end_y, line_color,
        input  ready
    );
    modport sink (
        input  valid, kind, start_x, start_y, end_x, end_y, line_color,
        output ready
    );
endinterface

// Output channel: one pixel per transfer.
interface lpg_pixel_if;
    logic                 valid;
    logic                 ready;
    lpg_pkg::t_coord      pixel_x;
    lpg_pkg::t_coord      pixel_y;
    lpg_pkg::t_color      pixel_color;
    logic                 last;

    modport source (
        output valid, pixel_x, pixel_y, pixel_color, last,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, pixel_color, last,
        output ready
    );
endinterface

[hdl/lpg_front.sv]
// ----------------------------------------------------------------------------
// Line pixel generator front end
// Accepts input items, classifies them and prepares the line set-up.
// ----------------------------------------------------------------------------
module lpg_front (
    lpg_line_if.sink        i_line,
    input  logic            i_full,
    output logic            o_push,
    output lpg_pkg::t_cmd   o_cmd
);

    logic            w_steep;
    lpg_pkg::t_coord w_a0;
    lpg_pkg::t_coord w_b0;
    lpg_pkg::t_coord w_a1;
    lpg_pkg::t_coord w_b1;

    // Items are taken whenever the queue has room.
    assign i_line.ready = !i_full;
    assign o_push       = i_line.valid && !i_full;

    // Pick the major axis: a steep line runs along y.
    assign w_steep = lpg_pkg::abs_diff(i_line.start_x, i_line.end_x)
                   < lpg_pkg::abs_diff(i_line.start_y, i_line.end_y);

    assign w_a0 = w_steep ? i_line.start_y : i_line.start_x;
    assign w_b0 = w_steep ? i_line.start_x : i_line.start_y;
    assign w_a1 = w_steep ? i_line.end_y   : i_line.end_x;
    assign w_b1 = w_steep ? i_line.end_x   : i_line.end_y;

    // Order the endpoints so that the major coordinate increases.
    always_comb begin
        o_cmd.kind  = lpg_pkg::t_kind'(i_line.kind);
        o_cmd.steep = w_steep;
        o_cmd.color = i_line.line_color;
        if (w_a0 > w_a1) begin
            o_cmd.major_lo = w_a1;
            o_cmd.minor_lo = w_b1;
            o_cmd.major_hi = w_a0;
            o_cmd.minor_hi = w_b0;
        end else begin
            o_cmd.major_lo = w_a0;
            o_cmd.minor_lo = w_b0;
            o_cmd.major_hi = w_a1;
            o_cmd.minor_hi = w_b1;
        end
    end

endmodule

[hdl/lpg_queue.sv]
// ----------------------------------------------------------------------------
// Line pixel generator command queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module lpg_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lpg_pkg::t_cmd   i_cmd,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output lpg_pkg::t_cmd   o_cmd
);

    lpg_pkg::t_cmd                   r_mem [lpg_pkg::QUEUE_DEPTH];
    logic [lpg_pkg::QUEUE_AW-1:0]    r_wr_ptr;
    logic [lpg_pkg::QUEUE_AW-1:0]    r_rd_ptr;
    logic [lpg_pkg::QUEUE_AW:0]      r_count;
    logic [lpg_pkg::QUEUE_AW:0]      n_count;

    assign o_full  = (r_count == (lpg_pkg::QUEUE_AW+1)'(lpg_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // Occupancy follows the push and pop transfers.
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

[hdl/lpg_back.sv]
// ----------------------------------------------------------------------------
// Line pixel generator back end
// Holds the active line, steps the Bresenham error term and drives pixels.
// ----------------------------------------------------------------------------
module lpg_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_empty,
    input  lpg_pkg::t_cmd         i_cmd,
    output logic                  o_pop,
    output lpg_pkg::t_back_status o_status,
    lpg_pixel_if.source           o_pixel
);

    // Line state.
    logic                            r_active;
    logic                            r_steep;
    lpg_pkg::t_coord                 r_cur_major;
    lpg_pkg::t_coord                 r_end_major;
    lpg_pkg::t_coord                 r_cur_minor;
    logic                            r_minor_down;
    lpg_pkg::t_coord                 r_major_span;
    logic [lpg_pkg::STEP_BITS-1:0]   r_error_step;
    logic [lpg_pkg::ERR_BITS-1:0]    r_error_acc;
    lpg_pkg::t_color                 r_held_color;

    // Output register.
    logic                            r_out_valid;
    lpg_pkg::t_coord                 r_pixel_x;
    lpg_pkg::t_coord                 r_pixel_y;
    lpg_pkg::t_color                 r_pixel_color;
    logic                            r_last;

    logic                            w_is_start;
    logic                            w_out_free;
    logic                            w_emit;
    logic                            w_is_last;
    logic [lpg_pkg::ERR_BITS-1:0]    w_acc_sum;
    logic [lpg_pkg::ERR_BITS-1:0]    w_two_span;
    logic                            w_minor_move;
    logic [lpg_pkg::ERR_BITS-1:0]    n_error_acc;
    lpg_pkg::t_coord                 n_cur_minor;

    // Head-of-queue decode: a start is always taken, a step needs a free
    // output slot only when a line is active.
    assign w_is_start = (i_cmd.kind == lpg_pkg::KIND_START);
    assign w_out_free = !r_out_valid || o_pixel.ready;
    assign o_pop      = !i_empty && (w_is_start || !r_active || w_out_free);
    assign w_emit     = !i_empty && !w_is_start && r_active && w_out_free;
    assign w_is_last  = (r_cur_major == r_end_major);

    // Error update: add twice the minor delta, step the minor axis on overflow.
    assign w_acc_sum    = r_error_acc + {1'b0, r_error_step};
    assign w_two_span   = {1'b0, r_major_span, 1'b0};
    assign w_minor_move = (w_acc_sum > w_two_span);
    assign n_error_acc  = w_minor_move ? (w_acc_sum - w_two_span) : w_acc_sum;

    always_comb begin
        n_cur_minor = r_cur_minor;
        if (w_minor_move) begin
            n_cur_minor = r_minor_down ? (r_cur_minor - 1'b1) : (r_cur_minor + 1'b1);
        end
    end

    // Line state: loaded by a start, advanced by every emitted pixel but the final one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (o_pop && w_is_start) begin
            r_active <= 1'b1;
        end else if (w_emit && w_is_last) begin
            r_active <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_is_start) begin
            r_steep      <= i_cmd.steep;
            r_cur_major  <= i_cmd.major_lo;
            r_end_major  <= i_cmd.major_hi;
            r_cur_minor  <= i_cmd.minor_lo;
            r_minor_down <= !(i_cmd.minor_hi > i_cmd.minor_lo);
            r_major_span <= i_cmd.major_hi - i_cmd.major_lo;
            r_error_step <= {lpg_pkg::abs_diff(i_cmd.minor_lo, i_cmd.minor_hi), 1'b0};
            r_error_acc  <= {2'b00, i_cmd.major_hi - i_cmd.major_lo};
            r_held_color <= i_cmd.color;
        end else if (w_emit && !w_is_last) begin
            r_cur_major  <= r_cur_major + 1'b1;
            r_cur_minor  <= n_cur_minor;
            r_error_acc  <= n_error_acc;
        end
    end

    // Output register: filled by an emitted pixel, emptied by a transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_pixel.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_pixel_x     <= r_steep ? r_cur_minor : r_cur_major;
            r_pixel_y     <= r_steep ? r_cur_major : r_cur_minor;
            r_pixel_color <= r_held_color;
            r_last        <= w_is_last;
        end
    end

    assign o_pixel.valid       = r_out_valid;
    assign o_pixel.pixel_x     = r_pixel_x;
    assign o_pixel.pixel_y     = r_pixel_y;
    assign o_pixel.pixel_color = r_pixel_color;
    assign o_pixel.last        = r_last;

    assign o_status.active    = r_active;
    assign o_status.emit      = w_emit;
    assign o_status.emit_last = w_emit && w_is_last;

endmodule

[hdl/line_pixel_generator_core.sv]
// ----------------------------------------------------------------------------
// Line pixel generator core
// Bresenham line rasteriser for all octants with a decoupled front and back.
// ----------------------------------------------------------------------------
// A start item (kind 0) sets up a line from its two endpoints and colour and
// produces no pixel; each step item (kind 1) then yields one pixel, from the
// lower end of the major axis to the upper end, with last set on the final
// one. A step with no line in progress is consumed and yields nothing. The
// block sustains one item per clock, start or step, while the output takes
// its pixels: the front classifies and orders the endpoints in the cycle of
// the transfer, a four-entry queue holds the items, and the back performs one
// error add, compare and subtract per pixel. When the queue is empty and the
// output register is free, a step item goes through the queue and then the
// output register, which presents its pixel on the output; a stalled output
// fills the queue before input ready drops.
// ----------------------------------------------------------------------------
module line_pixel_generator_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lpg_line_if.sink      i_line,
    lpg_pixel_if.source   o_pixel
);

    logic                  w_push;
    logic                  w_pop;
    logic                  w_full;
    logic                  w_empty;
    lpg_pkg::t_cmd         w_push_cmd;
    lpg_pkg::t_cmd         w_head_cmd;
    lpg_pkg::t_back_status w_status;

    // Front end: classification and endpoint ordering.
    lpg_front u_front (
        .i_line  (i_line),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_cmd   (w_push_cmd)
    );

    // Queue between the two halves.
    lpg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_cmd   (w_head_cmd)
    );

    // Back end: line stepping and pixel output.
    lpg_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_empty),
        .i_cmd    (w_head_cmd),
        .o_pop    (w_pop),
        .o_status (w_status),
        .o_pixel  (o_pixel)
    );

    // The back never takes an item from an empty queue.
    a_no_pop_empty: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty
    ) else $error("item taken from an empty queue");

    // Every emitted pixel consumes the step item that asked for it.
    a_emit_pops: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_status.emit |-> (w_pop && w_status.active)
    ) else $error("pixel emitted without consuming a step item");

    // The final pixel of a line closes it.
    a_last_closes: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_status.emit_last |=> (!w_status.active && o_pixel.valid && o_pixel.last)
    ) else $error("line still active after its final pixel");

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Line pixel generator core testbench
// Drives start and step items into the rasteriser, traces every line in a
// behavioural model of its own and checks each pixel transfer, field by field,
// against the oldest pixel still pending. Both channels idle at random, the
// output is held off for a long stretch once, and most of the stimulus is
// complete random lines in all octants with broken and abandoned ones mixed in.
// ----------------------------------------------------------------------------
module tb;

    localparam int COORD_MAX    = (1 << lpg_pkg::COORD_BITS) - 1;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_CYCLES = 20;

    // One pixel as the rasteriser should emit it.
    typedef struct {
        lpg_pkg::t_coord x;
        lpg_pkg::t_coord y;
        lpg_pkg::t_color color;
        logic            last;
    } t_pixel_rec;

    logic i_clk;
    logic i_rst_n;

    lpg_line_if  line_if ();
    lpg_pixel_if pix_if ();

    line_pixel_generator_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_line  (line_if),
        .o_pixel (pix_if)
    );

    // Line tracer state, mirroring the rasteriser.
    logic            line_on   = 1'b0;
    logic            line_steep = 1'b0;
    lpg_pkg::t_coord major_pos = '0;
    lpg_pkg::t_coord major_end = '0;
    lpg_pkg::t_coord minor_pos = '0;
    logic            minor_dec = 1'b0;
    int              span      = 0;
    int              err_inc   = 0;
    int              err_acc   = 0;
    lpg_pkg::t_color line_col  = '0;

    t_pixel_rec pending_pixels[$];
    int         useful_items = 0;
    int         faults       = 0;
    int         stall_cycles = 0;
    int         hold_left    = 0;
    bit         idle_on      = 1'b1;

    // Clock.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Advance the line tracer by one accepted item.
    task automatic trace_line_item(input lpg_pkg::t_kind kind,
                                   input lpg_pkg::t_coord x0, input lpg_pkg::t_coord y0,
                                   input lpg_pkg::t_coord x1, input lpg_pkg::t_coord y1,
                                   input lpg_pkg::t_color col);
        lpg_pkg::t_coord a0, b0, a1, b1, t;
        int              dxa, dya, dba;
        t_pixel_rec      pix;
        if (kind == lpg_pkg::KIND_START) begin
            dxa = (x0 > x1) ? int'(x0) - int'(x1) : int'(x1) - int'(x0);
            dya = (y0 > y1) ? int'(y0) - int'(y1) : int'(y1) - int'(y0);
            line_steep = (dxa < dya);
            if (line_steep) begin
                a0 = y0; b0 = x0; a1 = y1; b1 = x1;
            end else begin
                a0 = x0; b0 = y0; a1 = x1; b1 = y1;
            end
            if (a0 > a1) begin
                t = a0; a0 = a1; a1 = t;
                t = b0; b0 = b1; b1 = t;
            end
            dba = (b0 > b1) ? int'(b0) - int'(b1) : int'(b1) - int'(b0);
            major_pos = a0;
            major_end = a1;
            minor_pos = b0;
            minor_dec = !(b1 > b0);
            span      = int'(a1) - int'(a0);
            err_inc   = 2 * dba;
            err_acc   = span;
            line_col  = col;
            line_on   = 1'b1;
            useful_items++;
        end else if (line_on) begin
            pix.x     = line_steep ? minor_pos : major_pos;
            pix.y     = line_steep ? major_pos : minor_pos;
            pix.color = line_col;
            pix.last  = (major_pos == major_end);
            pending_pixels.push_back(pix);
            useful_items++;
            if (pix.last) begin
                line_on = 1'b0;
            end else begin
                major_pos = major_pos + 1'b1;
                err_acc   = err_acc + err_inc;
                if (err_acc > 2 * span) begin
                    minor_pos = minor_dec ? minor_pos - 1'b1 : minor_pos + 1'b1;
                    err_acc   = err_acc - 2 * span;
                end
            end
        end
    endtask

    // Offer one item and wait for its transfer. Valid stays high afterwards so
    // that back-to-back items need no gap.
    task automatic push_item(input lpg_pkg::t_kind kind,
                             input lpg_pkg::t_coord x0, input lpg_pkg::t_coord y0,
                             input lpg_pkg::t_coord x1, input lpg_pkg::t_coord y1,
                             input lpg_pkg::t_color col);
        int gap;
        @(negedge i_clk);
        if (idle_on && $urandom_range(99) < 10) begin
            gap = $urandom_range(1, 4);
            repeat (gap) begin
                line_if.valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        line_if.valid      <= 1'b1;
        line_if.kind       <= kind;
        line_if.start_x    <= x0;
        line_if.start_y    <= y0;
        line_if.end_x      <= x1;
        line_if.end_y      <= y1;
        line_if.line_color <= col;
        @(posedge i_clk);
        while (!line_if.ready) @(posedge i_clk);
        trace_line_item(kind, x0, y0, x1, y1, col);
    endtask

    // A step request; its endpoint and colour fields carry noise.
    task automatic push_step();
        push_item(lpg_pkg::KIND_STEP,
                  lpg_pkg::t_coord'($urandom), lpg_pkg::t_coord'($urandom),
                  lpg_pkg::t_coord'($urandom), lpg_pkg::t_coord'($urandom),
                  lpg_pkg::t_color'($urandom));
    endtask

    // Start a line and request a number of its pixels.
    task automatic run_line(input lpg_pkg::t_coord x0, input lpg_pkg::t_coord y0,
                            input lpg_pkg::t_coord x1, input lpg_pkg::t_coord y1,
                            input lpg_pkg::t_color col, input int steps);
        push_item(lpg_pkg::KIND_START, x0, y0, x1, y1, col);
        repeat (steps) push_step();
    endtask

    // Drop valid and wait until every pending pixel has been transferred.
    task automatic wait_for_pixels();
        @(negedge i_clk);
        line_if.valid <= 1'b0;
        while (pending_pixels.size() != 0) @(negedge i_clk);
    endtask

    function automatic int line_length(input lpg_pkg::t_coord x0, input lpg_pkg::t_coord y0,
                                       input lpg_pkg::t_coord x1, input lpg_pkg::t_coord y1);
        int dx, dy;
        dx = (x0 > x1) ? int'(x0) - int'(x1) : int'(x1) - int'(x0);
        dy = (y0 > y1) ? int'(y0) - int'(y1) : int'(y1) - int'(y0);
        return ((dx > dy) ? dx : dy) + 1;
    endfunction

    // A coordinate within reach of another one, clamped to the grid.
    function automatic lpg_pkg::t_coord near_coord(input lpg_pkg::t_coord c, input int reach);
        int v;
        v = int'(c) + int'($urandom_range(2 * reach)) - reach;
        if (v < 0) v = 0;
        if (v > COORD_MAX) v = COORD_MAX;
        return lpg_pkg::t_coord'(v);
    endfunction

    // Steps straight after reset find no line and must give nothing.
    task automatic test_idle_steps();
        push_step();
        push_step();
    endtask

    // Equal endpoints give one pixel, marked last; a further step gives none.
    task automatic test_single_point();
        run_line(12'd5, 12'd5, 12'd5, 12'd5, 32'hFFFF_FFFF, 2);
    endtask

    // Short lines against the edges of the grid, shallow and steep.
    task automatic test_edge_lines();
        run_line(12'd4095, 12'd4095, 12'd4093, 12'd4094, 32'h0000_0000, 3);
        run_line(12'd0, 12'd4095, 12'd1, 12'd4092, 32'hA5A5_5A5A, 4);
    endtask

    // A new start abandons a line in progress; the exact diagonal follows.
    task automatic test_abandon();
        run_line(12'd10, 12'd10, 12'd20, 12'd15, 32'h1234_5678, 2);
        run_line(12'd4095, 12'd0, 12'd4092, 12'd3, 32'hFFFF_FFFF, 5);
    endtask

    // The output is held off while steps keep coming, so the block fills up
    // and stalls its input; then the sender waits for every pixel.
    task automatic test_backpressure();
        hold_left = HOLD_CYCLES;
        run_line(12'd100, 12'd200, 12'd180, 12'd230, 32'hCAFE_F00D, 60);
        wait_for_pixels();
    endtask

    // Random lines in all octants, mostly complete, some broken off early,
    // some long ones abandoned, and stray steps.
    task automatic test_random_lines(input int count);
        int              goal, r, len, reach;
        lpg_pkg::t_coord x0, y0, x1, y1;
        lpg_pkg::t_color col;
        goal = useful_items + count;
        while (useful_items < goal) begin
            r   = $urandom_range(99);
            x0  = lpg_pkg::t_coord'($urandom_range(COORD_MAX));
            y0  = lpg_pkg::t_coord'($urandom_range(COORD_MAX));
            col = lpg_pkg::t_color'($urandom);
            if (r < 6) begin
                repeat ($urandom_range(1, 3)) push_step();
            end else if (r < 12) begin
                x1 = lpg_pkg::t_coord'($urandom_range(COORD_MAX));
                y1 = lpg_pkg::t_coord'($urandom_range(COORD_MAX));
                run_line(x0, y0, x1, y1, col, $urandom_range(1, 24));
            end else begin
                reach = ($urandom_range(3) == 0) ? 40 : 8;
                x1  = near_coord(x0, reach);
                y1  = near_coord(y0, reach);
                len = line_length(x0, y0, x1, y1);
                if (r < 20)
                    run_line(x0, y0, x1, y1, col, $urandom_range(0, len - 1));
                else
                    run_line(x0, y0, x1, y1, col, len + (($urandom_range(7) == 0) ? 1 : 0));
            end
        end
    endtask

    // Random lines with neither side idling.
    task automatic test_streaming(input int count);
        idle_on = 1'b0;
        test_random_lines(count);
        wait_for_pixels();
        idle_on = 1'b1;
    endtask

    // Output ready, with random idling and the long hold-off.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            pix_if.ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            pix_if.ready <= !(idle_on && $urandom_range(99) < 10);
        end
    end

    // Compare each pixel transfer with the oldest pending pixel.
    always @(posedge i_clk) begin
        t_pixel_rec want;
        if (i_rst_n && pix_if.valid && pix_if.ready) begin
            if (pending_pixels.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("%0t unexpected pixel x=%0d y=%0d colour=%h last=%b", $realtime,
                             pix_if.pixel_x, pix_if.pixel_y, pix_if.pixel_color, pix_if.last);
            end else begin
                want = pending_pixels.pop_front();
                if (pix_if.pixel_x !== want.x || pix_if.pixel_y !== want.y ||
                    pix_if.pixel_color !== want.color || pix_if.last !== want.last) begin
                    faults++;
                    if (faults <= 10) begin
                        $display("%0t pixel mismatch: expected x=%0d y=%0d colour=%h last=%b",
                                 $realtime, want.x, want.y, want.color, want.last);
                        $display("%0t pixel mismatch: got      x=%0d y=%0d colour=%h last=%b",
                                 $realtime, pix_if.pixel_x, pix_if.pixel_y,
                                 pix_if.pixel_color, pix_if.last);
                    end
                end
            end
        end
    end

    // Watchdog: too long without any transfer on either channel ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (line_if.valid && line_if.ready) || (pix_if.valid && pix_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("line_pixel_generator_core test failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Reset, then the tests in turn, then the final verdict.
    initial begin
        i_rst_n            = 1'b0;
        line_if.valid      = 1'b0;
        line_if.kind       = lpg_pkg::KIND_START;
        line_if.start_x    = '0;
        line_if.start_y    = '0;
        line_if.end_x      = '0;
        line_if.end_y      = '0;
        line_if.line_color = '0;
        pix_if.ready       = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_steps();
        test_single_point();
        test_edge_lines();
        test_abandon();
        wait_for_pixels();
        test_backpressure();
        test_random_lines(700);
        test_streaming(300);
        test_random_lines(700);
        wait_for_pixels();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (faults == 0 && pending_pixels.size() == 0) begin
            $display("line_pixel_generator_core test passed");
        end else begin
            $display("line_pixel_generator_core test failed");
        end
        $finish;
    end

endmodule
